[sv/assert_macros.svh]
// Assertion macros shared by the range checker RTL.
// Included by the top level; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

// When trig holds, cons must hold in the next cycle.
`define ASSERT_NEXT(lbl, trig, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) \
		else $error(msg);

`endif

[sv/ldhc_pkg.sv]
// Types and constants of the image header range checker.
// No dependencies; imported by every ldhc module.
package ldhc_pkg;

	localparam int AddrW = 16;
	// header sums reach start + length - 1 + bss, which needs two extra bits
	localparam int SumW  = 18;
	localparam int RegW  = 17;
	localparam int CfgIdxW  = 3;
	localparam int CfgDataW = 16;

	localparam logic [1:0] V_OK     = 2'd0;
	localparam logic [1:0] V_NOEXEC = 2'd1;
	localparam logic [1:0] V_NOMEM  = 2'd2;
	localparam logic [1:0] V_STACK  = 2'd3;

	localparam logic [CfgIdxW-1:0] CFG_EXPECTED_MAJOR = 3'd0;
	localparam logic [CfgIdxW-1:0] CFG_MAX_MINOR      = 3'd1;
	localparam logic [CfgIdxW-1:0] CFG_EXPECTED_CPU   = 3'd2;
	localparam logic [CfgIdxW-1:0] CFG_FLAG_LIMIT     = 3'd3;
	localparam logic [CfgIdxW-1:0] CFG_STACK_MINIMUM  = 3'd4;

	localparam logic [7:0] MAGIC0 = 8'h55;
	localparam logic [7:0] MAGIC1 = 8'h44;
	localparam logic [7:0] MAGIC2 = 8'h45;
	localparam logic [7:0] MAGIC3 = 8'h58;

	typedef struct packed {
		logic [7:0]  expected_major;
		logic [7:0]  max_minor;
		logic [7:0]  expected_cpu;
		logic [7:0]  flag_limit;
		logic [15:0] stack_minimum;
	} cfg_t;

	typedef struct packed {
		logic [1:0]      verdict;
		logic            img_keep;
		logic [AddrW-1:0] img_start;
		logic [SumW-1:0]  img_end;
		logic            stk_keep;
		logic [AddrW-1:0] stk_start;
		logic [SumW-1:0]  stk_end;
	} hdr_result_t;

endpackage

[sv/ldhc_header_check.sv]
// Header validation: identity bytes, image, entry and stack layout.
// Depends on ldhc_pkg.
module ldhc_header_check import ldhc_pkg::*; #(
	parameter int ADDRESS_BITS = 16
) (
	input  cfg_t             cfg,
	input  logic [63:0]      ident_bytes,
	input  logic [AddrW-1:0] image_start,
	input  logic [AddrW-1:0] image_length,
	input  logic [AddrW-1:0] zero_fill_length,
	input  logic [AddrW-1:0] entry_point,
	input  logic [AddrW-1:0] stack_start,
	input  logic [AddrW-1:0] stack_length,
	output hdr_result_t      res
);

	localparam logic [32:0] TopAddr = 33'((64'd1 << ADDRESS_BITS) - 64'd1);

	logic [SumW-1:0] img_last0;
	logic [SumW-1:0] img_last;
	logic [SumW-1:0] stk_last;
	logic            id_bad;

	assign img_last0 = SumW'(image_start) + SumW'(image_length) - SumW'(1);
	assign img_last  = img_last0 + SumW'(zero_fill_length);
	assign stk_last  = SumW'(stack_start) + SumW'(stack_length) - SumW'(1);

	assign id_bad = (ident_bytes[7:0] != MAGIC0) || (ident_bytes[15:8] != MAGIC1)
		|| (ident_bytes[23:16] != MAGIC2) || (ident_bytes[31:24] != MAGIC3)
		|| (ident_bytes[39:32] != cfg.expected_major)
		|| (ident_bytes[47:40] > cfg.max_minor)
		|| (ident_bytes[55:48] != cfg.expected_cpu)
		|| (ident_bytes[63:56] > cfg.flag_limit);

	always_comb begin
		res           = '0;
		res.img_start = image_start;
		res.img_end   = img_last;
		res.stk_start = stack_start;
		res.stk_end   = stk_last;
		if (id_bad || image_length == '0) begin
			res.verdict = V_NOEXEC;
		end else if (33'(img_last0) > TopAddr) begin
			res.verdict = V_NOMEM;
		end else if (entry_point < image_start || SumW'(entry_point) > img_last0) begin
			res.verdict = V_NOEXEC;
		end else if (33'(img_last) > TopAddr) begin
			res.verdict = V_NOMEM;
		end else begin
			res.img_keep = 1'b1;
			if (stack_length < cfg.stack_minimum || stack_length == '0
				|| 33'(stk_last) > TopAddr) begin
				res.verdict = V_STACK;
			end else begin
				res.stk_keep = 1'b1;
				if (SumW'(stack_start) <= img_last && SumW'(image_start) <= stk_last)
					res.verdict = V_STACK;
				else
					res.verdict = V_OK;
			end
		end
	end

endmodule

[sv/ldhc_region_check.sv]
// Reserved region test against the kept image and stack bounds.
// Depends on ldhc_pkg.
module ldhc_region_check import ldhc_pkg::*; #(
	parameter int ADDRESS_BITS = 16
) (
	input  logic [AddrW-1:0] region_start,
	input  logic [AddrW-1:0] region_length,
	input  logic [AddrW-1:0] img_start,
	input  logic [SumW-1:0]  img_end,
	input  logic [AddrW-1:0] stk_start,
	input  logic [SumW-1:0]  stk_end,
	output logic [1:0]       verdict
);

	localparam logic [32:0] TopAddr = 33'((64'd1 << ADDRESS_BITS) - 64'd1);

	logic [RegW-1:0] raw_last;
	logic [RegW-1:0] reg_last;
	logic            hit_img;
	logic            hit_stk;

	assign raw_last = RegW'(region_start) + RegW'(region_length) - RegW'(1);
	// saturate at the top of memory
	assign reg_last = (33'(raw_last) > TopAddr) ? TopAddr[RegW-1:0] : raw_last;

	assign hit_img = (SumW'(region_start) <= img_end) && (RegW'(img_start) <= reg_last);
	assign hit_stk = (SumW'(region_start) <= stk_end) && (RegW'(stk_start) <= reg_last);

	assign verdict = (region_length != '0 && (hit_img || hit_stk)) ? V_NOMEM : V_OK;

endmodule

[sv/load_image_header_range_checker.sv]
// Image header range checker: input stage, header and region checks, result register.
// Depends on ldhc_pkg, ldhc_header_check, ldhc_region_check, assert_macros.svh.
//
// Usage: a check is a run of requests on the s_axis channel. The first is a
// header request (tuser = 0) with identity bytes and image/stack words; any
// number of region requests (tuser = 1) follow. The request with tlast set
// produces one verdict on m_axis (0 ok, 1 not executable, 2 no memory,
// 3 invalid stack); other requests produce nothing.
// A request is registered in the input register at acceptance and checked
// there; its verdict enters the result register when the request moves on.
// Throughput: one request per cycle unless a tlast request waits on a held
// verdict; the header check is combinational between the two registers.
// Reset clears the kept bounds and the pending verdict to zero/ok and loads
// the register defaults. When m_axis stalls with a verdict held, requests
// without tlast keep flowing; a request with tlast waits in the input
// register and holds s_axis_tready low until the held verdict is taken.
// Configuration is written via cfg_we while no check is in flight.
`include "assert_macros.svh"

module load_image_header_range_checker import ldhc_pkg::*; #(
	parameter int ADDRESS_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	// ident_bytes[63:0], image_start, image_length, zero_fill_length,
	// entry_point, stack_start, stack_length, region_start, region_length
	input  logic [191:0]        s_axis_tdata,
	// mode
	input  logic                s_axis_tuser,
	input  logic                s_axis_tlast,
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	// verdict[1:0], zero padding
	output logic [7:0]          m_axis_tdata,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data
);

	cfg_t             cfg_q;
	logic             valid_s1;
	logic             mode_s1;
	logic             last_s1;
	logic [191:0]     data_s1;
	logic             out_valid_q;
	logic [1:0]       verdict_q;
	logic [1:0]       pending_q;
	logic [AddrW-1:0] img_start_q;
	logic [SumW-1:0]  img_end_q;
	logic [AddrW-1:0] stk_start_q;
	logic [SumW-1:0]  stk_end_q;

	logic             advance_s1;
	logic [1:0]       next_pending;
	logic [1:0]       reg_verdict;
	hdr_result_t      hdr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.expected_major <= 8'd1;
			cfg_q.max_minor      <= 8'd0;
			cfg_q.expected_cpu   <= 8'd0;
			cfg_q.flag_limit     <= 8'd2;
			cfg_q.stack_minimum  <= 16'd16;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_EXPECTED_MAJOR: cfg_q.expected_major <= cfg_data[7:0];
				CFG_MAX_MINOR:      cfg_q.max_minor      <= cfg_data[7:0];
				CFG_EXPECTED_CPU:   cfg_q.expected_cpu   <= cfg_data[7:0];
				CFG_FLAG_LIMIT:     cfg_q.flag_limit     <= cfg_data[7:0];
				CFG_STACK_MINIMUM:  cfg_q.stack_minimum  <= cfg_data;
				default: ;
			endcase
		end
	end

	// only a verdict-bearing request needs room in the result register
	assign advance_s1    = valid_s1 && (!last_s1 || !out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			mode_s1 <= s_axis_tuser;
			last_s1 <= s_axis_tlast;
			data_s1 <= s_axis_tdata;
		end
	end

	ldhc_header_check #(.ADDRESS_BITS(ADDRESS_BITS)) u_hdr (
		.cfg              (cfg_q),
		.ident_bytes      (data_s1[63:0]),
		.image_start      (data_s1[79:64]),
		.image_length     (data_s1[95:80]),
		.zero_fill_length (data_s1[111:96]),
		.entry_point      (data_s1[127:112]),
		.stack_start      (data_s1[143:128]),
		.stack_length     (data_s1[159:144]),
		.res              (hdr)
	);

	ldhc_region_check #(.ADDRESS_BITS(ADDRESS_BITS)) u_region (
		.region_start  (data_s1[175:160]),
		.region_length (data_s1[191:176]),
		.img_start     (img_start_q),
		.img_end       (img_end_q),
		.stk_start     (stk_start_q),
		.stk_end       (stk_end_q),
		.verdict       (reg_verdict)
	);

	always_comb begin
		if (!mode_s1)
			next_pending = hdr.verdict;
		else if (pending_q == V_OK)
			next_pending = reg_verdict;
		else
			next_pending = pending_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q   <= V_OK;
			img_start_q <= '0;
			img_end_q   <= '0;
			stk_start_q <= '0;
			stk_end_q   <= '0;
		end else if (advance_s1) begin
			pending_q <= next_pending;
			if (!mode_s1) begin
				// bounds not reached by a failing header read as zero
				img_start_q <= hdr.img_keep ? hdr.img_start : '0;
				img_end_q   <= hdr.img_keep ? hdr.img_end   : '0;
				stk_start_q <= hdr.stk_keep ? hdr.stk_start : '0;
				stk_end_q   <= hdr.stk_keep ? hdr.stk_end   : '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1 && last_s1)
			verdict_q <= next_pending;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {6'd0, verdict_q};

	`ASSERT_NEXT(a_last_gives_result, advance_s1 && last_s1, m_axis_tvalid, "verdict not presented")
	`ASSERT_ALWAYS(a_img_order, img_end_q >= SumW'(img_start_q), "image bounds inverted")
	`ASSERT_ALWAYS(a_stk_order, stk_end_q >= SumW'(stk_start_q), "stack bounds inverted")
	`ASSERT_NEXT(a_first_error_wins, advance_s1 && mode_s1 && pending_q != V_OK,
		pending_q == $past(pending_q), "region request changed a failed verdict")

endmodule
